/* sv/dscw_pkg.sv */
package dscw_pkg;

    // operation codes on the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_LINK  = 1'b1;

    // result status codes
    localparam logic [2:0] ST_FETCH = 3'd0;
    localparam logic [2:0] ST_END   = 3'd1;
    localparam logic [2:0] ST_LOOP  = 3'd2;
    localparam logic [2:0] ST_TRACK = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    // register word index on the config port
    localparam logic REG_IMAGE_SIZE = 1'b0;

    localparam int MAP_ROW_BITS = 64;
    localparam logic [7:0] HDR_LOW = 8'h40;           // 64-byte image header
    localparam logic [19:0] OFF_LIMIT = 20'h40000;
    localparam logic [7:0] FULL_EXTENT = 8'd254;      // sector minus link bytes

    typedef struct packed {
        logic [23:0] a;
        logic [23:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [23:0] sum;
        logic        gt;
    } alu_res_t;

    // sectors on all tracks below trk (trk counts from 1)
    function automatic logic [9:0] track_base(input logic [7:0] trk);
        logic [9:0] t;
        logic [9:0] r;
        t = {2'b00, trk};
        if (t <= 10'd18)
        begin
            r = 10'((t - 10'd1) * 10'd21);
        end
        else if (t <= 10'd25)
        begin
            r = 10'd357 + 10'((t - 10'd18) * 10'd19);
        end
        else if (t <= 10'd31)
        begin
            r = 10'd490 + 10'((t - 10'd25) * 10'd18);
        end
        else
        begin
            r = 10'd598 + 10'((t - 10'd31) * 10'd17);
        end
        return r;
    endfunction

endpackage

/* sv/dscw_alu.sv */
module dscw_alu (
    input  dscw_pkg::alu_req_t req,
    output dscw_pkg::alu_res_t res
);

    // one adder and one magnitude compare, shared by the link, accum, check, read and range steps
    always_comb
    begin
        res.sum = req.a + req.b;
        res.gt  = (req.a > req.b);
    end

endmodule

/* sv/dscw_map.sv */
module dscw_map #(
    parameter int ROWS = 160,
    parameter int ROW_W = 8
) (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [ROW_W-1:0]                  rd_addr,
    output logic [dscw_pkg::MAP_ROW_BITS-1:0] rd_data,
    input  logic                              wr_en,
    input  logic [ROW_W-1:0]                  wr_addr,
    input  logic [dscw_pkg::MAP_ROW_BITS-1:0] wr_data
);

    logic [dscw_pkg::MAP_ROW_BITS-1:0] mem [ROWS];
    logic [dscw_pkg::MAP_ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/disk_sector_chain_walker_top.sv */
// sector chain walker for a zoned disk image with a 64-byte header
// input channel (in_valid/in_ready): op 0 starts a chain at track/sector,
// op 1 hands over the two link bytes of the current sector
// output channel (out_valid/out_ready): one result beat per input beat with
// status, next_offset of the sector to fetch, the payload extent and total
// a link beat steps through link, accum, check, read and range around one
// shared adder/compare and the visited-map read-modify-write, ending early
// at a chain end, bad track or loop; with no active chain it goes to done
// a start beat first clears the visited map one 64-bit row a cycle, then
// checks, reads and range-tests its first sector like a link
// one beat is in flight at a time; in_ready is high only while idle
// the result sits in an output register: a stalled receiver holds it there,
// and the next beat is still taken, but its result waits for that slot
// reset clears chain state and the image size register; the visited map is
// not cleared at reset since no link is walked before a start clears it
// image_size is written over the apb port at byte address 0
module disk_sector_chain_walker_top #(
    parameter int MAX_TRACK = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  track,
    input  logic [7:0]  sector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [17:0] next_offset,
    output logic        extent_valid,
    output logic [17:0] extent_offset,
    output logic [7:0]  extent_size,
    output logic [21:0] total_size
);

    localparam int ROWS  = MAX_TRACK * 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int RB    = dscw_pkg::MAP_ROW_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LINK  = 8'b0000_0010,
        S_ACCUM = 8'b0000_0100,
        S_CLEAR = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_RANGE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0]      size_reg;
    logic             op_reg, op_next;
    logic [7:0]       trk_reg, trk_next;
    logic [7:0]       sec_reg, sec_next;
    logic [17:0]      off_reg, off_next;
    logic [21:0]      total_reg, total_next;
    logic             active_reg, active_next;
    logic [2:0]       end_reg, end_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    logic [10:0]      sum_reg, sum_next;
    logic [19:0]      end_off_reg, end_off_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic             res_ev_reg, res_ev_next;
    logic [17:0]      res_eoff_reg, res_eoff_next;
    logic [7:0]       res_esize_reg, res_esize_next;

    logic             o_valid_reg, o_valid_next;
    logic [2:0]       o_status_reg, o_status_next;
    logic [17:0]      o_next_off_reg, o_next_off_next;
    logic             o_ev_reg, o_ev_next;
    logic [17:0]      o_eoff_reg, o_eoff_next;
    logic [7:0]       o_esize_reg, o_esize_next;
    logic [21:0]      o_total_reg, o_total_next;

    dscw_pkg::alu_req_t alu_req;
    dscw_pkg::alu_res_t alu_res;

    logic             mem_rd_en;
    logic             mem_wr_en;
    logic [ROW_W-1:0] mem_wr_addr;
    logic [RB-1:0]    mem_wr_data;
    logic [RB-1:0]    mem_rd_data;
    logic [9:0]       row_full;
    logic [ROW_W-1:0] row_addr;
    logic             in_fire;
    logic             out_free;
    logic             cfg_write;
    logic [7:0]       link_esize;

    dscw_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    dscw_map #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_map (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (row_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == dscw_pkg::REG_IMAGE_SIZE);
    assign prdata    = (paddr[2] == dscw_pkg::REG_IMAGE_SIZE) ? {8'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (cfg_write)
        begin
            size_reg <= pwdata[23:0];
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !o_valid_reg || out_ready;

    // each map row holds the 64 sectors of one quarter track
    assign row_full = {trk_reg - 8'd1, sec_reg[7:6]};
    assign row_addr = row_full[ROW_W-1:0];

    assign link_esize = (trk_reg == 8'd0) ?
                        ((sec_reg >= 8'd2) ? (sec_reg - 8'd1) : 8'd0) :
                        dscw_pkg::FULL_EXTENT;

    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_LINK:
            begin
                alu_req.a = {6'd0, off_reg};
                alu_req.b = 24'd2;
            end
            S_ACCUM:
            begin
                alu_req.a = {2'd0, total_reg};
                alu_req.b = {16'd0, res_esize_reg};
            end
            S_CHECK:
            begin
                alu_req.a = {14'd0, dscw_pkg::track_base(trk_reg)};
                alu_req.b = {16'd0, sec_reg};
            end
            S_READ:
            begin
                alu_req.a = {13'd0, sum_reg};
                alu_req.b = 24'd1;
            end
            S_RANGE:
            begin
                alu_req.a = {4'd0, end_off_reg};
                alu_req.b = size_reg;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        trk_next        = trk_reg;
        sec_next        = sec_reg;
        off_next        = off_reg;
        total_next      = total_reg;
        active_next     = active_reg;
        end_next        = end_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        end_off_next    = end_off_reg;
        res_status_next = res_status_reg;
        res_ev_next     = res_ev_reg;
        res_eoff_next   = res_eoff_reg;
        res_esize_next  = res_esize_reg;
        o_valid_next    = o_valid_reg && !out_ready;
        o_status_next   = o_status_reg;
        o_next_off_next = o_next_off_reg;
        o_ev_next       = o_ev_reg;
        o_eoff_next     = o_eoff_reg;
        o_esize_next    = o_esize_reg;
        o_total_next    = o_total_reg;
        mem_rd_en       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = row_addr;
        mem_wr_data     = mem_rd_data | (RB'(1) << sec_reg[5:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next        = op;
                    trk_next       = track;
                    sec_next       = sector;
                    res_ev_next    = 1'b0;
                    res_eoff_next  = '0;
                    res_esize_next = '0;
                    if (op == dscw_pkg::OP_START)
                    begin
                        total_next = '0;
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else if (!active_reg)
                    begin
                        res_status_next = end_reg;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK:
            begin
                res_esize_next = link_esize;
                res_ev_next    = (link_esize != 8'd0);
                res_eoff_next  = (link_esize != 8'd0) ? alu_res.sum[17:0] : 18'd0;
                state_next     = S_ACCUM;
            end
            S_ACCUM:
            begin
                if (res_ev_reg)
                begin
                    total_next = alu_res.sum[21:0];
                end
                if (trk_reg == 8'd0)
                begin
                    res_status_next = dscw_pkg::ST_END;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_reg;
                mem_wr_data = '0;
                cnt_next    = cnt_reg + ROW_W'(1);
                if (cnt_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                sum_next = alu_res.sum[10:0];
                if (trk_reg == 8'd0)
                begin
                    res_status_next = dscw_pkg::ST_END;
                    state_next      = S_DONE;
                end
                else if (trk_reg > 8'(MAX_TRACK))
                begin
                    res_status_next = dscw_pkg::ST_TRACK;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (mem_rd_data[sec_reg[5:0]])
                begin
                    res_status_next = dscw_pkg::ST_LOOP;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_wr_en    = 1'b1;
                    end_off_next = {alu_res.sum[11:0], dscw_pkg::HDR_LOW};
                    state_next   = S_RANGE;
                end
            end
            S_RANGE:
            begin
                // end of sector beyond the image or beyond the offset width
                if (alu_res.gt || (end_off_reg > dscw_pkg::OFF_LIMIT))
                begin
                    res_status_next = dscw_pkg::ST_RANGE;
                end
                else
                begin
                    res_status_next = dscw_pkg::ST_FETCH;
                    off_next        = {sum_reg[9:0], dscw_pkg::HDR_LOW};
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    // a link beat with no active chain leaves the chain state alone
                    if ((op_reg == dscw_pkg::OP_START) || active_reg)
                    begin
                        active_next = (res_status_reg == dscw_pkg::ST_FETCH);
                        if (res_status_reg != dscw_pkg::ST_FETCH)
                        begin
                            end_next = res_status_reg;
                        end
                    end
                    o_valid_next    = 1'b1;
                    o_status_next   = res_status_reg;
                    o_next_off_next = (res_status_reg == dscw_pkg::ST_FETCH) ? off_reg : 18'd0;
                    o_ev_next       = res_ev_reg;
                    o_eoff_next     = res_eoff_reg;
                    o_esize_next    = res_esize_reg;
                    o_total_next    = total_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            off_reg     <= '0;
            total_reg   <= '0;
            active_reg  <= 1'b0;
            end_reg     <= dscw_pkg::ST_END;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            off_reg     <= off_next;
            total_reg   <= total_next;
            active_reg  <= active_next;
            end_reg     <= end_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        trk_reg        <= trk_next;
        sec_reg        <= sec_next;
        cnt_reg        <= cnt_next;
        sum_reg        <= sum_next;
        end_off_reg    <= end_off_next;
        res_status_reg <= res_status_next;
        res_ev_reg     <= res_ev_next;
        res_eoff_reg   <= res_eoff_next;
        res_esize_reg  <= res_esize_next;
        o_status_reg   <= o_status_next;
        o_next_off_reg <= o_next_off_next;
        o_ev_reg       <= o_ev_next;
        o_eoff_reg     <= o_eoff_next;
        o_esize_reg    <= o_esize_next;
        o_total_reg    <= o_total_next;
    end

    assign out_valid     = o_valid_reg;
    assign status        = o_status_reg;
    assign next_offset   = o_next_off_reg;
    assign extent_valid  = o_ev_reg;
    assign extent_offset = o_eoff_reg;
    assign extent_size   = o_esize_reg;
    assign total_size    = o_total_reg;

endmodule

/* sv/dscw_checker.sv */
module dscw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [17:0] next_offset,
    input logic        extent_valid,
    input logic [17:0] extent_offset,
    input logic [7:0]  extent_size
);

    // a result beat that is not taken stays up with status and next_offset unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(next_offset))
        else $error("result beat dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= dscw_pkg::ST_RANGE)
        else $error("status code out of range");

    a_no_fetch_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dscw_pkg::ST_FETCH |-> next_offset == 18'd0)
        else $error("next_offset set on a terminated walk");

    a_empty_extent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !extent_valid |-> extent_size == 8'd0 && extent_offset == 18'd0)
        else $error("extent fields set without an extent");

    // only the final sector of a chain can carry a short extent
    a_full_extent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && extent_valid && status != dscw_pkg::ST_END
        |-> extent_size == dscw_pkg::FULL_EXTENT)
        else $error("short extent on a sector that links onward");

endmodule

bind disk_sector_chain_walker_top dscw_checker u_dscw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .next_offset   (next_offset),
    .extent_valid  (extent_valid),
    .extent_offset (extent_offset),
    .extent_size   (extent_size)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_TRACK     = 40;
    localparam int MAP_SIZE      = MAX_TRACK * 256;
    localparam int IMG_HDR_BYTES = 64;
    localparam int SECTOR_BYTES  = 256;
    localparam int OFFSET_SPAN   = 32'h40000;
    localparam int DRAIN_CYCLES  = 20;
    localparam logic [23:0] D64_IMAGE = 24'd174912;   // 683 sectors plus header
    localparam logic [23:0] D40_IMAGE = 24'd196672;   // 768 sectors plus header

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] next_off;
        logic        ext_valid;
        logic [17:0] ext_off;
        logic [7:0]  ext_size;
        logic [21:0] total;
    } walk_res_t;

    typedef struct packed {
        bit        given;
        walk_res_t res;
    } row_result_t;

    typedef struct packed {
        bit          cfg;
        logic [23:0] size;
        logic        op;
        logic [7:0]  trk;
        logic [7:0]  sec;
        bit          given;
        walk_res_t   res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [7:0]  track;
    logic [7:0]  sector;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [17:0] next_offset;
    logic        extent_valid;
    logic [17:0] extent_offset;
    logic [7:0]  extent_size;
    logic [21:0] total_size;

    // predictor state
    bit [MAP_SIZE-1:0] walk_visited;
    logic [17:0]       walk_offset;
    logic [21:0]       walk_total;
    bit                walk_active;
    logic [2:0]        walk_end_status;
    logic [23:0]       walk_image_size;

    walk_res_t   pending_results[$];
    row_result_t row_results[$];
    dir_row_t    dir_rows[$];

    // stimulus bookkeeping for the chain being generated
    bit [MAP_SIZE-1:0] gen_used;

    int error_count;
    int beats_sent;
    int results_seen;
    int burst_left;

    disk_sector_chain_walker_top #(
        .MAX_TRACK(MAX_TRACK)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .track(track),
        .sector(sector),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .next_offset(next_offset),
        .extent_valid(extent_valid),
        .extent_offset(extent_offset),
        .extent_size(extent_size),
        .total_size(total_size)
    );

    always #5 clk = ~clk;

    function automatic int zone_sectors(input int trk);
        if (trk <= 17)
        begin
            return 21;
        end
        if (trk <= 24)
        begin
            return 19;
        end
        if (trk <= 30)
        begin
            return 18;
        end
        return 17;
    endfunction

    // marks the sector visited and returns its status
    function automatic logic [2:0] claim_sector(input logic [7:0] trk, input logic [7:0] sec);
        int tn;
        int idx;
        int off;
        int t;
        tn = int'(trk);
        if (tn == 0)
        begin
            return dscw_pkg::ST_END;
        end
        if (tn > MAX_TRACK)
        begin
            return dscw_pkg::ST_TRACK;
        end
        idx = (tn - 1) * 256 + int'(sec);
        if (walk_visited[idx])
        begin
            return dscw_pkg::ST_LOOP;
        end
        walk_visited[idx] = 1'b1;
        off = IMG_HDR_BYTES + SECTOR_BYTES * int'(sec);
        for (t = 1; t < tn; t++)
        begin
            off += zone_sectors(t) * SECTOR_BYTES;
        end
        if (off + SECTOR_BYTES > int'(walk_image_size) || off + SECTOR_BYTES > OFFSET_SPAN)
        begin
            return dscw_pkg::ST_RANGE;
        end
        walk_offset = 18'(off);
        return dscw_pkg::ST_FETCH;
    endfunction

    function automatic walk_res_t predict_walk(input logic o, input logic [7:0] trk,
                                               input logic [7:0] sec);
        walk_res_t r;
        logic [2:0] st;
        int esize;
        r = '0;
        if (o == dscw_pkg::OP_START)
        begin
            walk_visited = '0;
            walk_total = '0;
            st = claim_sector(trk, sec);
        end
        else if (!walk_active)
        begin
            st = walk_end_status;
        end
        else
        begin
            if (trk == 8'd0)
            begin
                esize = (sec >= 8'd2) ? int'(sec) - 1 : 0;
                st = dscw_pkg::ST_END;
            end
            else
            begin
                esize = SECTOR_BYTES - 2;
            end
            if (esize > 0)
            begin
                r.ext_valid = 1'b1;
                r.ext_off = walk_offset + 18'd2;
                r.ext_size = 8'(esize);
                walk_total = 22'(walk_total + esize);
            end
            if (trk != 8'd0)
            begin
                st = claim_sector(trk, sec);
            end
        end
        if (o == dscw_pkg::OP_START || walk_active)
        begin
            walk_active = (st == dscw_pkg::ST_FETCH);
            if (st != dscw_pkg::ST_FETCH)
            begin
                walk_end_status = st;
            end
        end
        r.status = st;
        r.next_off = (st == dscw_pkg::ST_FETCH) ? walk_offset : 18'd0;
        r.total = walk_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_result();
        walk_res_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result beat, status", int'(status), 0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch("status", int'(status), int'(want.status));
            if (next_offset !== want.next_off)
                report_mismatch("next_offset", int'(next_offset), int'(want.next_off));
            if (extent_valid !== want.ext_valid)
                report_mismatch("extent_valid", int'(extent_valid), int'(want.ext_valid));
            if (extent_offset !== want.ext_off)
                report_mismatch("extent_offset", int'(extent_offset), int'(want.ext_off));
            if (extent_size !== want.ext_size)
                report_mismatch("extent_size", int'(extent_size), int'(want.ext_size));
            if (total_size !== want.total)
                report_mismatch("total_size", int'(total_size), int'(want.total));
        end
    endtask

    always @(posedge clk)
    begin : beat_monitor
        row_result_t booked;
        walk_res_t guess;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                guess = predict_walk(op, track, sector);
                booked = row_results.pop_front();
                pending_results.push_back(booked.given ? booked.res : guess);
            end
            if (out_valid && out_ready)
            begin
                check_result();
            end
        end
    end

    // receiver: segments of steady, random, sparse or toggling ready, plus long hold-offs
    initial
    begin : result_sink
        int mode;
        int seg_left;
        int hold_left;
        int holds_done;
        mode = 0;
        seg_left = 0;
        hold_left = 0;
        holds_done = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_done < 2 && results_seen >= 400 * (holds_done + 1))
            begin
                holds_done++;
                hold_left = 400;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    task automatic offer_beat(input logic o, input logic [7:0] t, input logic [7:0] s,
                              input bit given, input walk_res_t res);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        row_results.push_back('{given, res});
        in_valid <= 1'b1;
        op <= o;
        track <= t;
        sector <= s;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_seen < beats_sent);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // write, then read back over the apb port
    task automatic write_image_size(input logic [23:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {dscw_pkg::REG_IMAGE_SIZE, 2'b00};
        pwdata <= {8'd0, size};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        walk_image_size = size;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[23:0] !== size)
            report_mismatch("prdata", int'(prdata[23:0]), int'(size));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input logic o, input int t, input int s);
        dir_rows.push_back('{1'b0, 24'd0, o, 8'(t), 8'(s), 1'b0, walk_res_t'('0)});
    endtask

    task automatic add_typed(input logic o, input int t, input int s, input logic [2:0] st,
                             input int noff, input int ev, input int eoff, input int esz,
                             input int tot);
        walk_res_t r;
        r = '{st, 18'(noff), 1'(ev), 18'(eoff), 8'(esz), 22'(tot)};
        dir_rows.push_back('{1'b0, 24'd0, o, 8'(t), 8'(s), 1'b1, r});
    endtask

    task automatic pick_fresh(output int t, output int s);
        int tries;
        for (tries = 0; tries < 8; tries++)
        begin
            t = $urandom_range(1, MAX_TRACK);
            s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, zone_sectors(t) - 1);
            if (!gen_used[(t - 1) * 256 + s])
                break;
        end
        gen_used[(t - 1) * 256 + s] = 1'b1;
    endtask

    task automatic run_phase(input int n_items);
        int sent;
        int r;
        int len;
        int k;
        int t;
        int s;
        int first_t;
        int first_s;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                // well-formed chain with random content
                gen_used = '0;
                pick_fresh(first_t, first_s);
                offer_beat(dscw_pkg::OP_START, 8'(first_t), 8'(first_s), 1'b0, '0);
                r = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(0, 8)
                    : (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 150);
                for (k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 92)
                    begin
                        pick_fresh(t, s);
                    end
                    else if (r < 96)
                    begin
                        t = first_t;
                        s = first_s;
                    end
                    else
                    begin
                        t = $urandom_range(1, 255);
                        s = $urandom_range(0, 255);
                    end
                    offer_beat(dscw_pkg::OP_LINK, 8'(t), 8'(s), 1'b0, '0);
                end
                offer_beat(dscw_pkg::OP_LINK, 8'd0, 8'($urandom_range(0, 255)), 1'b0, '0);
                sent += len + 2;
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    offer_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b0, '0);
                sent += len;
            end
            else
            begin
                // broken chain: odd start, then stray links
                offer_beat(dscw_pkg::OP_START, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b0, '0);
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    offer_beat(dscw_pkg::OP_LINK, 8'($urandom_range(0, 60)),
                               8'($urandom_range(0, 255)), 1'b0, '0);
                sent += len + 1;
            end
        end
    endtask

    initial
    begin
        #50_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        logic [23:0] size;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = dscw_pkg::OP_START;
        track = '0;
        sector = '0;
        error_count = 0;
        beats_sent = 0;
        results_seen = 0;
        burst_left = 0;
        walk_visited = '0;
        walk_offset = '0;
        walk_total = '0;
        walk_active = 1'b0;
        walk_end_status = dscw_pkg::ST_END;
        walk_image_size = '0;
        gen_used = '0;

        // image size is zero out of reset
        add_typed(dscw_pkg::OP_LINK,    0,   0, dscw_pkg::ST_END,   0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_START,   0,   0, dscw_pkg::ST_END,   0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_START,  41,   0, dscw_pkg::ST_TRACK, 0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_START, 255, 255, dscw_pkg::ST_TRACK, 0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_START,   1,   0, dscw_pkg::ST_RANGE, 0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_LINK,    5,   5, dscw_pkg::ST_RANGE, 0, 0, 0, 0, 0);
        dir_rows.push_back('{1'b1, D64_IMAGE, dscw_pkg::OP_START, 8'd0, 8'd0, 1'b0,
                             walk_res_t'('0)});
        add_typed(dscw_pkg::OP_START,   1,   0, dscw_pkg::ST_FETCH, 64, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_LINK,    1,   1, dscw_pkg::ST_FETCH, 320, 1, 66, 254, 254);
        add_row(dscw_pkg::OP_LINK,  18,   0);
        add_row(dscw_pkg::OP_LINK,   1,   0);     // back to the first sector
        add_row(dscw_pkg::OP_LINK,   3,   3);     // link after the loop ended the walk
        add_row(dscw_pkg::OP_START, 35,  16);     // last sector that fits the image
        add_row(dscw_pkg::OP_LINK,  35,  17);
        add_typed(dscw_pkg::OP_START,  36,   0, dscw_pkg::ST_RANGE, 0, 0, 0, 0, 0);
        add_typed(dscw_pkg::OP_START,  40, 255, dscw_pkg::ST_RANGE, 0, 0, 0, 0, 0);
        add_row(dscw_pkg::OP_START,  2,   0);
        add_row(dscw_pkg::OP_LINK,   2,   1);
        add_row(dscw_pkg::OP_LINK,   0,   1);     // last-used index below 2, no extent
        add_row(dscw_pkg::OP_START,  3,   0);
        add_row(dscw_pkg::OP_LINK,   0,   2);
        add_row(dscw_pkg::OP_START,  4,   0);
        add_row(dscw_pkg::OP_LINK,   0, 255);
        add_row(dscw_pkg::OP_LINK,   0, 255);
        dir_rows.push_back('{1'b1, 24'hFFFFFF, dscw_pkg::OP_START, 8'd0, 8'd0, 1'b0,
                             walk_res_t'('0)});
        add_row(dscw_pkg::OP_START, 40, 255);
        add_row(dscw_pkg::OP_LINK, 255, 255);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg)
            begin
                drain();
                write_image_size(dir_rows[i].size);
            end
            else
            begin
                offer_beat(dir_rows[i].op, dir_rows[i].trk, dir_rows[i].sec,
                           dir_rows[i].given, dir_rows[i].res);
            end
        end

        for (p = 0; p < 6; p++)
        begin
            case (p)
                0: size = D64_IMAGE;
                1: size = 24'hFFFFFF;
                2: size = 24'($urandom_range(0, 262400));
                3: size = 24'd0;
                4: size = D40_IMAGE;
                default: size = 24'($urandom);
            endcase
            drain();
            write_image_size(size);
            run_phase((p == 3) ? 100 : 350);
        end

        drain();
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
